/* hw/rtl/process_slot_table_macros.svh */
// Assertion macros for the RTL of the process slot table.
`ifndef PROCESS_SLOT_TABLE_MACROS_SVH
`define PROCESS_SLOT_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
`define PST_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PST_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/pst_pkg.sv */
`timescale 1ns / 1ps
package pst_pkg;

    localparam logic [1:0] KIND_SPAWN = 2'd0;
    localparam logic [1:0] KIND_KILL  = 2'd1;
    localparam logic [1:0] KIND_WAIT  = 2'd2;
    localparam logic [1:0] KIND_GET   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_RUNNING   = 2'd3;

    localparam logic signed [31:0] EXIT_KILLED = -32'sd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] target_id;
        logic [7:0]  new_priority;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        new_id;
        logic               slot_state;
        logic [7:0]         slot_priority_out;
        logic signed [31:0] exit_value;
    } t_rsp;

    typedef struct packed {
        logic [31:0]        id;
        logic               zombie;
        logic [7:0]         prio;
        logic signed [31:0] exit_val;
    } t_entry;

endpackage

/* hw/rtl/process_slot_table.sv */
`timescale 1ns / 1ps
// Process slot table with SLOTS entries.
// A transaction is accepted at a rising edge where start is high and busy is
// low; i_req carries the operation, the target identifier and the priority.
// Spawn takes the lowest free slot and returns a fresh nonzero identifier.
// Kill, wait and get look up the lowest slot whose identifier matches.
// Each transaction yields exactly one response on o_rsp, marked by o_done for
// a single cycle; the receiver cannot hold it off, so it must take it then.
// The lookup walks the slot memory one entry per cycle with a registered read.
// A spawn checks the occupancy flags in slot order and takes the first free
// one, or answers full. A lookup compares each read entry in slot order and
// stops at the first match, or answers not found. The response is registered
// then, and busy falls together with o_done, so a new transaction may start.
// Reset clears all occupancy flags and sets the identifier counter to one;
// no clearing pass over the memory is needed.
`include "process_slot_table_macros.svh"
module process_slot_table
    import pst_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
    localparam int EW = $bits(t_entry);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state      r_state, n_state;
    t_req        r_req, n_req;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_pidx, n_pidx;
    logic        r_pend, n_pend;
    logic        r_iss_done, n_iss_done;
    logic [SLOTS-1:0] r_used, n_used;
    logic [31:0] r_ctr, n_ctr;
    logic        r_done, n_done;
    t_rsp        r_rsp, n_rsp;

    logic        we;
    logic [IW-1:0] waddr;
    t_entry      wdata;
    t_entry      rd;
    logic [EW-1:0] rd_bits;
    logic        hit;

    pst_ram #(
        .WIDTH(EW),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(r_idx),
        .o_rdata(rd_bits)
    );

    assign rd  = t_entry'(rd_bits);
    assign hit = r_pend && r_used[r_pidx] && (rd.id == r_req.target_id);

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_idx      = r_idx;
        n_pidx     = r_pidx;
        n_pend     = 1'b0;
        n_iss_done = r_iss_done;
        n_used     = r_used;
        n_ctr      = r_ctr;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        we         = 1'b0;
        waddr      = r_idx;
        wdata      = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state    = S_SCAN;
                    n_req      = i_req;
                    n_idx      = '0;
                    n_iss_done = 1'b0;
                end
            end
            S_SCAN: begin
                if (r_req.kind == KIND_SPAWN) begin
                    if (!r_used[r_idx]) begin
                        we              = 1'b1;
                        waddr           = r_idx;
                        wdata.id        = r_ctr;
                        wdata.zombie    = 1'b0;
                        wdata.prio      = r_req.new_priority;
                        wdata.exit_val  = '0;
                        n_used[r_idx]   = 1'b1;
                        n_ctr           = (r_ctr == '1) ? 32'd1 : r_ctr + 32'd1;
                        n_rsp           = '0;
                        n_rsp.status    = ST_OK;
                        n_rsp.new_id    = r_ctr;
                        n_rsp.slot_priority_out = r_req.new_priority;
                        n_done          = 1'b1;
                        n_state         = S_IDLE;
                    end else if (r_idx == LAST) begin
                        n_rsp        = '0;
                        n_rsp.status = ST_FULL;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_pend = !r_iss_done;
                    n_pidx = r_idx;
                    if (r_idx == LAST) begin
                        n_iss_done = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                    if (hit) begin
                        n_pend  = 1'b0;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                        n_rsp   = '0;
                        n_rsp.status            = ST_OK;
                        n_rsp.slot_state        = rd.zombie;
                        n_rsp.slot_priority_out = rd.prio;
                        n_rsp.exit_value        = rd.exit_val;
                        case (r_req.kind)
                            KIND_KILL: begin
                                we              = 1'b1;
                                waddr           = r_pidx;
                                wdata           = rd;
                                wdata.zombie    = 1'b1;
                                wdata.exit_val  = EXIT_KILLED;
                                n_rsp.slot_state = 1'b1;
                                n_rsp.exit_value = EXIT_KILLED;
                            end
                            KIND_WAIT: begin
                                if (rd.zombie) begin
                                    n_used[r_pidx] = 1'b0;
                                end else begin
                                    n_rsp.status = ST_RUNNING;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end else if (r_pend && r_pidx == LAST) begin
                        n_pend       = 1'b0;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                        n_rsp        = '0;
                        n_rsp.status = ST_NOT_FOUND;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend     <= 1'b0;
            r_iss_done <= 1'b0;
            r_used     <= '0;
            r_ctr      <= 32'd1;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend     <= n_pend;
            r_iss_done <= n_iss_done;
            r_used     <= n_used;
            r_ctr      <= n_ctr;
            r_done     <= n_done;
        end
        r_req  <= n_req;
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_rsp  <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `PST_ASSERT_IMPLY(a_done_not_busy, i_clk, i_rst_n, o_done, !busy)
    `PST_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy && !o_done)
    `PST_ASSERT_IMPLY(a_full_no_id, i_clk, i_rst_n,
        o_done && (o_rsp.status == ST_FULL), (o_rsp.new_id == 32'd0) && (r_used == '1))
    `PST_ASSERT_IMPLY(a_ctr_nonzero, i_clk, i_rst_n, 1'b1, r_ctr != 32'd0)

endmodule

/* hw/rtl/pst_ram.sv */
`timescale 1ns / 1ps
module pst_ram #(
    parameter int WIDTH = 73,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
